@@ rtl/assert_macros.svh @@
// Assertion macros used by the interpolator core.
// Expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the cycle where ante holds
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/eti_pkg.sv @@
// Types, codes and constants of the enthalpy table interpolator.
// No dependencies.
package eti_pkg;

    localparam int ETI_TABLE_ROWS = 64;
    localparam int ETI_ROW_W      = 56;   // {pressure 24, enthalpy 32}
    localparam int ETI_DIVD_W     = 57;   // dividend magnitude width
    localparam int ETI_DIVS_W     = 24;   // divisor width

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] TBL_LIQUID = 2'd0;
    localparam logic [1:0] TBL_VAPOR  = 2'd1;
    localparam logic [1:0] TBL_SUPER  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_RANGE      = 2'd2;
    localparam logic [1:0] ST_NO_BRACKET = 2'd3;

    localparam logic [2:0] CFG_LOW_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_HIGH_LIMIT = 3'd1;
    localparam logic [2:0] CFG_LIQ_ROWS   = 3'd2;
    localparam logic [2:0] CFG_VAP_ROWS   = 3'd3;
    localparam logic [2:0] CFG_SUP_ROWS   = 3'd4;

    localparam logic signed [31:0] MINUS_ONE_Q16 = 32'shFFFF0000;
    localparam logic signed [31:0] INT32_MAX     = 32'sh7FFFFFFF;

    // x/1000 == (x * ADJ_RECIP) >> ADJ_SHIFT for every x below 2^28
    localparam logic [28:0] ADJ_RECIP = 29'd274877907;
    localparam int          ADJ_SHIFT = 38;

    typedef struct packed {
        logic               operation;
        logic [1:0]         table_select;
        logic [5:0]         row_index;
        logic [23:0]        row_pressure;
        logic signed [31:0] row_enthalpy;
        logic [23:0]        query_pressure;
        logic signed [15:0] fluid_temperature;
        logic signed [15:0] ambient_temp;
        logic signed [15:0] surrounding_temp;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] enthalpy_out;
        logic [1:0]         status;
        logic [1:0]         table_used;
    } out_item_t;

    typedef struct packed {
        logic                  start;
        logic [ETI_DIVD_W-1:0] dividend;
        logic [ETI_DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [ETI_DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/eti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/eti_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on eti_pkg.
module eti_div
    import eti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(ETI_DIVD_W + 1);

    logic [CW-1:0]         cnt_reg;
    logic                  done_reg;
    logic [ETI_DIVD_W-1:0] q_reg;
    logic [ETI_DIVS_W:0]   rem_reg;
    logic [ETI_DIVS_W-1:0] dvs_reg;
    logic [ETI_DIVS_W:0]   rem_sh;
    logic                  fits;

    assign rem_sh = {rem_reg[ETI_DIVS_W-1:0], q_reg[ETI_DIVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= CW'(ETI_DIVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            q_reg   <= {q_reg[ETI_DIVD_W-2:0], fits};
        end
    end

    assign rsp.busy     = cnt_reg != '0;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

@@ rtl/enthalpy_table_interpolator_core.sv @@
// Enthalpy table interpolator: row store, bracket scan, interpolation, correction.
// Load: the row is written, then the result is registered. Query: row ends read, bracket
// scan, then the bit-serial divider for the interpolation quotient; errors end sooner.
// One item in flight; the next is taken once the result is in the output stage.
// Reset clears control state and config registers; the row RAM is not cleared.
// Depends on eti_pkg, eti_ram, eti_div and assert_macros.svh.
`include "assert_macros.svh"
module enthalpy_table_interpolator_core
    import eti_pkg::*;
#(
    parameter int TABLE_ROWS = ETI_TABLE_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [23:0] cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int DEPTH = 3 * TABLE_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RCW   = $clog2(TABLE_ROWS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIRST = 10'b0000000010,
        S_LAST  = 10'b0000000100,
        S_SCAN  = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_SEL   = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_ADJ   = 10'b0010000000,
        S_CORR  = 10'b0100000000,
        S_PUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0]    low_limit_reg, high_limit_reg;
    logic [RCW-1:0] liq_rows_reg, vap_rows_reg, sup_rows_reg, clamp_rows;

    logic [23:0]          p_reg;
    logic [RCW-1:0]       n_reg, idx_reg;
    logic [AW-1:0]        base_reg;
    logic signed [30:0]   tsum_reg;
    logic [21:0]          adj_reg;
    logic [ETI_ROW_W-1:0] prev_reg;
    logic [23:0]          p1_reg, p2_reg;
    logic signed [31:0]   h1_reg, h2_reg, h_reg;
    logic signed [56:0]   num_reg;
    logic [23:0]          den_reg;
    out_item_t            res_reg;
    out_item_t            out_data_reg;
    logic                 out_valid_reg;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [ETI_ROW_W-1:0] ram_rdata;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 accept, out_load;
    logic [1:0]           q_tbl;
    logic [RCW-1:0]       q_n;
    logic [23:0]          cur_p, prev_p;
    logic signed [31:0]   cur_h;
    logic signed [32:0]   h_diff;
    logic signed [56:0]   num_mag;
    logic [30:0]          tsum_mag;
    logic [59:0]          adj_prod;
    logic signed [33:0]   q_signed, adj_signed, h_sum;
    logic signed [30:0]   tsum_calc;

    eti_ram #(.WIDTH(ETI_ROW_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_data.row_pressure, in_data.row_enthalpy}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    eti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = state_reg != S_IDLE;
    assign out_load = (state_reg == S_PUT) && (!out_valid_reg || !out_stall);

    // counts are taken from cfg_data[6:0]; values above the table size saturate
    always_comb
    begin
        if ({25'd0, cfg_data[6:0]} > TABLE_ROWS)
        begin
            clamp_rows = RCW'(TABLE_ROWS);
        end
        else
        begin
            clamp_rows = RCW'(cfg_data[6:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= '0;
            high_limit_reg <= '0;
            liq_rows_reg   <= '0;
            vap_rows_reg   <= '0;
            sup_rows_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                CFG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                CFG_LIQ_ROWS:   liq_rows_reg   <= clamp_rows;
                CFG_VAP_ROWS:   vap_rows_reg   <= clamp_rows;
                CFG_SUP_ROWS:   sup_rows_reg   <= clamp_rows;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (in_data.query_pressure <= low_limit_reg)
        begin
            q_tbl = TBL_LIQUID;
            q_n   = liq_rows_reg;
        end
        else if (in_data.query_pressure <= high_limit_reg)
        begin
            q_tbl = TBL_VAPOR;
            q_n   = vap_rows_reg;
        end
        else
        begin
            q_tbl = TBL_SUPER;
            q_n   = sup_rows_reg;
        end
    end

    assign tsum_calc = (31'(in_data.fluid_temperature) <<< 11)
                     + (31'(in_data.fluid_temperature) <<< 9)
                     + (31'(in_data.ambient_temp) <<< 10)
                     + (31'(in_data.ambient_temp) <<< 8)
                     + (31'(in_data.surrounding_temp) <<< 9)
                     + (31'(in_data.surrounding_temp) <<< 8);

    assign cur_p    = ram_rdata[55:32];
    assign cur_h    = ram_rdata[31:0];
    assign prev_p   = prev_reg[55:32];
    assign h_diff   = 33'(h2_reg) - 33'(h1_reg);
    assign num_mag  = num_reg[56] ? -num_reg : num_reg;
    assign tsum_mag = tsum_reg[30] ? 31'(-tsum_reg) : 31'(tsum_reg);
    // correction magnitude / 1000 by reciprocal multiplication
    assign adj_prod = 60'(tsum_mag) * 60'(ADJ_RECIP);
    assign q_signed = num_reg[56] ? -34'(div_rsp.quotient) : 34'(div_rsp.quotient);
    assign adj_signed = tsum_reg[30] ? -34'(adj_reg) : 34'(adj_reg);
    assign h_sum    = 34'(h_reg) + adj_signed;

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = AW'(in_data.table_select) * AW'(TABLE_ROWS) + AW'(in_data.row_index);
        ram_re     = 1'b0;
        ram_raddr  = base_reg + AW'(idx_reg + 1'b1);
        div_req.start    = 1'b0;
        div_req.dividend = ETI_DIVD_W'(unsigned'(num_mag));
        div_req.divisor  = den_reg;
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = AW'(q_tbl) * AW'(TABLE_ROWS);
                if (accept)
                begin
                    if (in_data.operation == OP_LOAD)
                    begin
                        ram_we = (in_data.table_select != 2'd3)
                              && ({26'd0, in_data.row_index} < TABLE_ROWS);
                        state_next = S_PUT;
                    end
                    else if (q_n == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                ram_re     = 1'b1;
                ram_raddr  = base_reg + AW'(n_reg - 1'b1);
                state_next = S_LAST;
            end
            S_LAST:
            begin
                if (p_reg < prev_p || p_reg > cur_p || n_reg == RCW'(1))
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = base_reg + AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (p_reg >= prev_p && p_reg <= cur_p)
                begin
                    state_next = S_MUL;
                end
                else if (RCW'(idx_reg + 1'b1) == n_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            S_MUL:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                if (den_reg == '0)
                begin
                    state_next = S_ADJ;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_ADJ;
                end
            end
            S_ADJ:
            begin
                if (h_reg < 0)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_CORR;
                end
            end
            S_CORR:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                p_reg    <= in_data.query_pressure;
                n_reg    <= q_n;
                base_reg <= AW'(q_tbl) * AW'(TABLE_ROWS);
                tsum_reg <= tsum_calc;
                idx_reg  <= RCW'(1);
                if (in_data.operation == OP_LOAD)
                begin
                    res_reg.enthalpy_out <= '0;
                    res_reg.status       <= ST_OK;
                    res_reg.table_used   <= ram_we ? in_data.table_select : TBL_LIQUID;
                end
                else
                begin
                    res_reg.enthalpy_out <= MINUS_ONE_Q16;
                    res_reg.status       <= ST_EMPTY;
                    res_reg.table_used   <= q_tbl;
                end
            end
            S_FIRST:
            begin
                prev_reg <= ram_rdata;
            end
            S_LAST:
            begin
                res_reg.status <= (p_reg < prev_p || p_reg > cur_p) ? ST_RANGE
                                                                     : ST_NO_BRACKET;
            end
            S_SCAN:
            begin
                p1_reg   <= prev_p;
                h1_reg   <= prev_reg[31:0];
                p2_reg   <= cur_p;
                h2_reg   <= cur_h;
                prev_reg <= ram_rdata;
                idx_reg  <= RCW'(idx_reg + 1'b1);
            end
            S_MUL:
            begin
                num_reg <= h_diff * $signed({1'b0, p_reg - p1_reg});
                den_reg <= p2_reg - p1_reg;
            end
            S_SEL:
            begin
                h_reg <= h1_reg;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    h_reg <= 32'(34'(h1_reg) + q_signed);
                end
            end
            S_ADJ:
            begin
                res_reg.status       <= ST_OK;
                res_reg.enthalpy_out <= h_reg;
                adj_reg              <= 22'(adj_prod >> ADJ_SHIFT);
            end
            S_CORR:
            begin
                res_reg.enthalpy_out <= (h_sum > 34'(INT32_MAX)) ? INT32_MAX
                                                                 : 32'(h_sum);
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_IMPLIES(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `ASSERT_HOLDS(a_ram_one_access, !(ram_we && ram_re), "row RAM read and written together")
    `ASSERT_IMPLIES(a_err_minus_one, out_valid && out_data.status != ST_OK, out_data.enthalpy_out == MINUS_ONE_Q16, "error result not -1.0")

endmodule

@@ dv/enthalpy_table_interpolator_core_tb.sv @@
// Testbench for enthalpy_table_interpolator_core: loads tables and queries enthalpies,
// checks every transfer against an in-bench predictor under random idling and stalls.
// Depends on eti_pkg and the core RTL.
module enthalpy_table_interpolator_core_tb;
    import eti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS      = ETI_TABLE_ROWS;
    localparam int HOLD_LONG = 400;
    localparam int DRAIN_CYC = 300;
    localparam int WDOG_MAX  = 20000;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;

    enthalpy_table_interpolator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor state
    logic [23:0]        low_lim;
    logic [23:0]        high_lim;
    logic [6:0]         row_count [0:2];
    logic [23:0]        pres_store [0:3*ROWS-1];
    logic signed [31:0] enth_store [0:3*ROWS-1];

    out_item_t expected_q[$];
    int        mismatches;
    int        items_sent;
    bit        no_gaps;
    bit        quiet_rx;
    bit        hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_item_t predict_enthalpy(in_item_t it);
        out_item_t   r;
        int          n;
        int          base;
        int          addr;
        longint      res;
        longint      p;
        longint      p1;
        longint      p2;
        longint      h1;
        longint      h2;
        longint      adj;
        logic [1:0]  st;
        logic [1:0]  used;
        used = TBL_LIQUID;
        st   = ST_OK;
        res  = 0;
        if (it.operation == OP_LOAD)
        begin
            if (it.table_select != 2'd3)
            begin
                addr = int'(it.table_select) * ROWS + int'(it.row_index);
                pres_store[addr] = it.row_pressure;
                enth_store[addr] = it.row_enthalpy;
                used = it.table_select;
            end
        end
        else
        begin
            p = longint'({1'b0, it.query_pressure});
            if (it.query_pressure <= low_lim)
                used = TBL_LIQUID;
            else if (it.query_pressure <= high_lim)
                used = TBL_VAPOR;
            else
                used = TBL_SUPER;
            n = int'(row_count[used]);
            if (n > ROWS)
                n = ROWS;
            base = int'(used) * ROWS;
            if (n == 0)
            begin
                st = ST_EMPTY;
            end
            else if (it.query_pressure < pres_store[base] ||
                     it.query_pressure > pres_store[base + n - 1])
            begin
                st = ST_RANGE;
            end
            else
            begin
                st = ST_NO_BRACKET;
                for (int i = 0; i + 1 < n; i++)
                begin
                    p1 = longint'({1'b0, pres_store[base + i]});
                    p2 = longint'({1'b0, pres_store[base + i + 1]});
                    if (p >= p1 && p <= p2)
                    begin
                        h1 = longint'(enth_store[base + i]);
                        h2 = longint'(enth_store[base + i + 1]);
                        if (p2 == p1)
                            res = h1;
                        else
                            res = h1 + ((h2 - h1) * (p - p1)) / (p2 - p1);
                        st = ST_OK;
                        break;
                    end
                end
            end
            if (st != ST_OK)
            begin
                res = longint'(MINUS_ONE_Q16);
            end
            else if (res >= 0)
            begin
                adj = (longint'(it.fluid_temperature) * 2560 +
                       longint'(it.ambient_temp) * 1280 +
                       longint'(it.surrounding_temp) * 768) / 1000;
                res = res + adj;
                if (res > longint'(INT32_MAX))
                    res = longint'(INT32_MAX);
            end
        end
        r.enthalpy_out = res[31:0];
        r.status       = st;
        r.table_used   = used;
        return r;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.operation         = 1'($urandom);
        it.table_select      = 2'($urandom);
        it.row_index         = 6'($urandom);
        it.row_pressure      = 24'($urandom);
        it.row_enthalpy      = $urandom;
        it.query_pressure    = 24'($urandom);
        it.fluid_temperature = 16'($urandom);
        it.ambient_temp      = 16'($urandom);
        it.surrounding_temp  = 16'($urandom);
        return it;
    endfunction

    function automatic in_item_t query_item(logic [23:0] p);
        in_item_t it;
        it = rand_item();
        it.operation      = OP_QUERY;
        it.query_pressure = p;
        return it;
    endfunction

    function automatic in_item_t load_item(logic [1:0] tbl, logic [5:0] idx,
                                           logic [23:0] p, logic [31:0] h);
        in_item_t it;
        it = rand_item();
        it.operation    = OP_LOAD;
        it.table_select = tbl;
        it.row_index    = idx;
        it.row_pressure = p;
        it.row_enthalpy = h;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        expected_q.push_back(predict_enthalpy(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_LOW_LIMIT:  low_lim = val;
            CFG_HIGH_LIMIT: high_lim = val;
            CFG_LIQ_ROWS:   row_count[TBL_LIQUID] = val[6:0];
            CFG_VAP_ROWS:   row_count[TBL_VAPOR] = val[6:0];
            CFG_SUP_ROWS:   row_count[TBL_SUPER] = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [23:0] lo, logic [23:0] hi,
                              logic [6:0] nl, logic [6:0] nv, logic [6:0] ns);
        wait_idle();
        write_reg(CFG_LOW_LIMIT, lo);
        write_reg(CFG_HIGH_LIMIT, hi);
        write_reg(CFG_LIQ_ROWS, 24'(nl));
        write_reg(CFG_VAP_ROWS, 24'(nv));
        write_reg(CFG_SUP_ROWS, 24'(ns));
    endtask

    // ascending pressures across [plo, phi], with the odd repeated pressure
    task automatic load_table(logic [1:0] tbl, int n, longint plo, longint phi);
        longint step;
        longint p;
        longint prev;
        logic [31:0] h;
        if (phi < plo)
            phi = plo;
        step = (phi - plo) / (n > 0 ? n : 1);
        prev = plo;
        for (int i = 0; i < n; i++)
        begin
            p = plo + i * step + (step > 1 ? $urandom_range(0, 32'(step / 2)) : 0);
            if (i > 0 && $urandom_range(0, 7) == 0)
                p = prev;
            if (p > phi)
                p = phi;
            prev = p;
            h = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            send_item(load_item(tbl, 6'(i), 24'(p), h));
        end
    endtask

    // receiver: random holds, quiet stretches, and one long hold on request
    initial
    begin : receiver
        int stall_cycles;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_cycles = HOLD_LONG;
            end
            else
            begin
                stall_cycles = quiet_rx ? 0 : $urandom_range(0, 16);
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", out_data);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.enthalpy_out !== want.enthalpy_out ||
                    out_data.status !== want.status ||
                    out_data.table_used !== want.table_used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected h=%0h st=%0d tbl=%0d, ",
                                  "got h=%0h st=%0d tbl=%0d"},
                                 want.enthalpy_out, want.status, want.table_used,
                                 out_data.enthalpy_out, out_data.status,
                                 out_data.table_used);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("enthalpy_table_interpolator_core test failed");
                $finish;
            end
        end
    end

    // tables unloaded: every query reports an empty table, no row is read; a load to table 3 writes nothing
    task automatic test_empty_tables();
        set_config(24'h0, 24'h0, 7'd0, 7'd0, 7'd0);
        send_item(query_item(24'h0));
        send_item(query_item(24'hFF_FFFF));
        send_item(load_item(2'd3, 6'd63, 24'h12_3456, 32'h1234_5678));
        set_config(24'hFF_FFFF, 24'hFF_FFFF, 7'd0, 7'd0, 7'd0);
        send_item(query_item(24'hFF_FFFF));
        set_config(24'h10, 24'h20, 7'd0, 7'd0, 7'd0);
        send_item(query_item(24'h18));
    endtask

    task automatic test_load_all();
        load_table(TBL_LIQUID, ROWS, 0, 24'h40_0000);
        load_table(TBL_VAPOR, ROWS, 24'h40_0001, 24'h90_0000);
        load_table(TBL_SUPER, ROWS, 24'h90_0001, 24'hFF_FFFF);
    endtask

    task automatic test_special_cases();
        in_item_t it;
        send_item(load_item(TBL_LIQUID, 6'd0, 24'h100, 32'd4000));
        send_item(load_item(TBL_LIQUID, 6'd1, 24'h100, 32'd8000));
        send_item(load_item(TBL_LIQUID, 6'd2, 24'h200, -32'sd200000));
        send_item(load_item(TBL_LIQUID, 6'd3, 24'h300, -32'sd100000));
        send_item(load_item(TBL_VAPOR, 6'd0, 24'h1800, 32'd5000));
        send_item(load_item(TBL_SUPER, 6'd0, 24'h3000, 32'h7FFF_FFF0));
        send_item(load_item(TBL_SUPER, 6'd1, 24'h4000, 32'h7FFF_FFF8));
        set_config(24'h1000, 24'h2000, 7'd4, 7'd1, 7'd2);
        send_item(query_item(24'h100));     // equal bracket pressures
        send_item(query_item(24'h180));     // negative interpolation
        send_item(query_item(24'h280));
        send_item(query_item(24'h50));      // below first row
        send_item(query_item(24'h350));     // above last row
        send_item(query_item(24'h1800));    // single row
        send_item(query_item(24'h1900));
        it = query_item(24'h3800);          // saturates
        it.fluid_temperature = 16'sh7FFF;
        it.ambient_temp      = 16'sh7FFF;
        it.surrounding_temp  = 16'sh7FFF;
        send_item(it);
        it = query_item(24'h100);
        it.fluid_temperature = 16'sh8000;
        it.ambient_temp      = 16'sh8000;
        it.surrounding_temp  = 16'sh8000;
        send_item(it);
        set_config(24'h1000, 24'h2000, 7'd64, 7'd127, 7'd127);
        send_item(query_item(24'h180));
        send_item(query_item(24'h1900));
        send_item(query_item(24'hFF_FFFF));
    endtask

    task automatic test_random_traffic(int target);
        logic [23:0] lo;
        logic [23:0] hi;
        int          nr [0:2];
        int          phase;
        in_item_t    it;
        phase = 0;
        while (items_sent < target)
        begin
            no_gaps  = (phase % 4 == 3);
            quiet_rx = (phase % 4 == 3);
            lo = 24'($urandom_range(0, 24'h80_0000));
            hi = lo + 24'($urandom_range(0, 24'h7F_FFFF));
            for (int t = 0; t < 3; t++)
            begin
                case ($urandom_range(0, 9))
                    0:       nr[t] = 0;
                    1:       nr[t] = 1;
                    2:       nr[t] = 127;
                    default: nr[t] = $urandom_range(2, 12);
                endcase
            end
            set_config(lo, hi, 7'(nr[0]), 7'(nr[1]), 7'(nr[2]));
            load_table(TBL_LIQUID, nr[0] > ROWS ? ROWS : nr[0], 0, lo);
            load_table(TBL_VAPOR, nr[1] > ROWS ? ROWS : nr[1], longint'(lo) + 1, hi);
            load_table(TBL_SUPER, nr[2] > ROWS ? ROWS : nr[2], longint'(hi) + 1,
                       24'hFF_FFFF);
            for (int q = 0; q < 40; q++)
            begin
                if ($urandom_range(0, 9) == 0)
                    it = rand_item();
                else
                    it = query_item(24'($urandom));
                send_item(it);
            end
            phase++;
        end
        no_gaps  = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // receiver holds off while queries keep coming, so the input stalls
    task automatic test_backpressure();
        hold_request = 1'b1;
        no_gaps = 1'b1;
        for (int i = 0; i < 8; i++)
            send_item(query_item(24'($urandom)));
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_idle();
        for (int i = 0; i < 6; i++)
            send_item(query_item(24'($urandom)));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_LOW_LIMIT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        mismatches   = 0;
        items_sent   = 0;
        no_gaps      = 1'b0;
        quiet_rx     = 1'b0;
        hold_request = 1'b0;
        low_lim      = '0;
        high_lim     = '0;
        for (int t = 0; t < 3; t++)
            row_count[t] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_tables();
        test_load_all();
        test_special_cases();
        test_backpressure();
        test_drain_pause();
        test_random_traffic(750);
        test_backpressure();

        wait_idle();
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("enthalpy_table_interpolator_core test passed");
        else
            $display("enthalpy_table_interpolator_core test failed");
        $finish;
    end

endmodule

@@ enthalpy_table_interpolator_core.f @@
+incdir+rtl
rtl/eti_pkg.sv
rtl/eti_ram.sv
rtl/eti_div.sv
rtl/enthalpy_table_interpolator_core.sv
dv/enthalpy_table_interpolator_core_tb.sv
